>>> design/lpd_pkg.sv
// Shared types and constants for the length-prefix deframer.
package lpd_pkg;

    localparam int HEADER_BYTES = 4;
    localparam int HDR_CNT_W = $clog2(HEADER_BYTES);
    localparam int LEN_W = 8 * HEADER_BYTES;
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

    localparam logic [PADDR_W-1:0] ADDR_MAX_FRAME = PADDR_W'(0);
    localparam logic [LEN_W-1:0] MAX_FRAME_RESET = LEN_W'(1048576);
    localparam logic [HDR_CNT_W-1:0] HDR_CNT_LAST = HDR_CNT_W'(HEADER_BYTES - 1);

    typedef enum logic [2:0] {
        ST_PROGRESS      = 3'd0,
        ST_OK            = 3'd1,
        ST_CLEAN_END     = 3'd2,
        ST_TRUNC_HEADER  = 3'd3,
        ST_EMPTY         = 3'd4,
        ST_OVERSIZE      = 3'd5,
        ST_TRUNC_PAYLOAD = 3'd6
    } lpd_status_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        end_of_stream;
    } lpd_item_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        is_payload;
        logic        last_of_frame;
        lpd_status_t status;
    } lpd_result_t;

endpackage

>>> design/lpd_regs.sv
// APB configuration register holding the maximum frame length.
module lpd_regs
    import lpd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [LEN_W-1:0]   max_frame_bytes
);

    logic [LEN_W-1:0] max_frame_reg;
    logic [LEN_W-1:0] max_frame_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        max_frame_next = max_frame_reg;
        if (wr_en && (paddr == ADDR_MAX_FRAME))
        begin
            max_frame_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_reg <= MAX_FRAME_RESET;
        end
        else
        begin
            max_frame_reg <= max_frame_next;
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_MAX_FRAME: prdata = max_frame_reg;
            default:        prdata = '0;
        endcase
    end

    assign max_frame_bytes = max_frame_reg;

endmodule

>>> design/lpd_core.sv
// Deframer datapath: input register, header/payload tracking and result register.
module lpd_core
    import lpd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [LEN_W-1:0] max_frame_bytes,
    input  logic             in_valid,
    output logic             in_stall,
    input  lpd_item_t        in_item,
    output logic             out_valid,
    input  logic             out_stall,
    output lpd_result_t      out_result
);

    logic             in_vld_reg;
    logic             in_vld_next;
    lpd_item_t        in_item_reg;
    logic             in_accept;
    logic             advance;

    logic [HDR_CNT_W-1:0] hdr_cnt_reg;
    logic [HDR_CNT_W-1:0] hdr_cnt_next;
    logic [LEN_W-1:0]     gather_reg;
    logic [LEN_W-1:0]     gather_next;
    logic [LEN_W-1:0]     remain_reg;
    logic [LEN_W-1:0]     remain_next;
    logic                 in_payload_reg;
    logic                 in_payload_next;

    logic [LEN_W-1:0]     len_full;
    logic                 has_result;
    lpd_result_t          result;

    logic                 out_vld_reg;
    logic                 out_vld_next;
    lpd_result_t          out_result_reg;

    assign advance   = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
    end

    assign len_full = {gather_reg[LEN_W-9:0], in_item_reg.data_byte};

    always_comb
    begin
        hdr_cnt_next    = hdr_cnt_reg;
        gather_next     = gather_reg;
        remain_next     = remain_reg;
        in_payload_next = in_payload_reg;
        has_result      = 1'b0;
        result          = '{payload_byte: 8'd0, is_payload: 1'b0,
                            last_of_frame: 1'b0, status: ST_PROGRESS};
        if (advance)
        begin
            if (in_item_reg.end_of_stream)
            begin
                has_result = 1'b1;
                if (in_payload_reg)
                begin
                    result.status = ST_TRUNC_PAYLOAD;
                end
                else if (hdr_cnt_reg == '0)
                begin
                    result.status = ST_CLEAN_END;
                end
                else
                begin
                    result.status = ST_TRUNC_HEADER;
                end
                hdr_cnt_next    = '0;
                gather_next     = '0;
                remain_next     = '0;
                in_payload_next = 1'b0;
            end
            else if (!in_payload_reg)
            begin
                if (hdr_cnt_reg == HDR_CNT_LAST)
                begin
                    hdr_cnt_next = '0;
                    gather_next  = '0;
                    if (len_full == '0)
                    begin
                        has_result    = 1'b1;
                        result.status = ST_EMPTY;
                    end
                    else if (len_full > max_frame_bytes)
                    begin
                        has_result    = 1'b1;
                        result.status = ST_OVERSIZE;
                    end
                    else
                    begin
                        in_payload_next = 1'b1;
                        remain_next     = len_full;
                    end
                end
                else
                begin
                    hdr_cnt_next = hdr_cnt_reg + HDR_CNT_W'(1);
                    gather_next  = len_full;
                end
            end
            else
            begin
                has_result          = 1'b1;
                result.payload_byte = in_item_reg.data_byte;
                result.is_payload   = 1'b1;
                if (remain_reg == LEN_W'(1))
                begin
                    result.last_of_frame = 1'b1;
                    result.status        = ST_OK;
                    remain_next          = '0;
                    in_payload_next      = 1'b0;
                end
                else
                begin
                    remain_next = remain_reg - LEN_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (advance && has_result)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_vld_reg && !out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            hdr_cnt_reg    <= '0;
            gather_reg     <= '0;
            remain_reg     <= '0;
            in_payload_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg     <= in_vld_next;
            out_vld_reg    <= out_vld_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            gather_reg     <= gather_next;
            remain_reg     <= remain_next;
            in_payload_reg <= in_payload_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_item_reg <= in_item;
        end
        if (advance && has_result)
        begin
            out_result_reg <= result;
        end
    end

    assign out_valid  = out_vld_reg;
    assign out_result = out_result_reg;

    a_payload_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> (remain_reg != '0))
        else $error("payload phase with zero bytes remaining");

    a_header_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        !in_payload_reg |-> (remain_reg == '0))
        else $error("stale payload count during header collection");

    a_last_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_result_reg.last_of_frame
            |-> out_result_reg.is_payload && (out_result_reg.status == ST_OK))
        else $error("last byte of frame without ok status");

    a_final_byte_ends: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !in_item_reg.end_of_stream && in_payload_reg
            && (remain_reg == LEN_W'(1)) |=> !in_payload_reg && (hdr_cnt_reg == '0))
        else $error("final payload byte did not return to header collection");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_vld_reg && out_vld_reg && out_stall)
        else $error("input stalled without output back-pressure");

endmodule

>>> design/length_prefix_deframer_unit.sv
// Top level of the length-prefix deframer with its APB register port.
// The block accepts one stream item per clock cycle while in_stall is low.
// An accepted item waits in the input register while the header/payload
// logic works on it, and its result, if any, is then written to the result
// register with out_valid high. Header bytes produce no result unless the
// length they give is zero or larger than max_frame_bytes;
// payload bytes, length errors and end-of-stream markers each produce one.
// Throughput is one item per cycle as long as the output side does not stall;
// the result register holding a stalled result is what back-pressures the
// input. max_frame_bytes is at byte address 0.
module length_prefix_deframer_unit
    import lpd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               end_of_stream,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         payload_byte,
    output logic               is_payload,
    output logic               last_of_frame,
    output logic [2:0]         status
);

    logic [LEN_W-1:0] max_frame_bytes;
    lpd_item_t        in_item;
    lpd_result_t      out_result;

    assign in_item.data_byte     = data_byte;
    assign in_item.end_of_stream = end_of_stream;

    lpd_regs u_regs (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .max_frame_bytes (max_frame_bytes)
    );

    lpd_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .max_frame_bytes (max_frame_bytes),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_item         (in_item),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_result      (out_result)
    );

    assign payload_byte  = out_result.payload_byte;
    assign is_payload    = out_result.is_payload;
    assign last_of_frame = out_result.last_of_frame;
    assign status        = out_result.status;

endmodule
